### hdl/fdr_pkg.sv
// Shared types, constants and arithmetic step functions for the Fresnel reflectance pipeline.
`timescale 1ns / 1ps

package fdr_pkg;

    localparam int unsigned SQ_STEPS  = 16;   // root bits of a Q1.15 square root
    localparam int unsigned DIV_STEPS = 31;   // quotient bits of the cosine division
    localparam int unsigned RAT_STEPS = 25;   // quotient bits of one Q1.24 ratio

    localparam logic [15:0] ETA_OUTSIDE_RST = 16'd4096;
    localparam logic [15:0] ETA_INSIDE_RST  = 16'd6144;
    localparam logic [30:0] ONE_Q30         = 31'h4000_0000;
    localparam logic [24:0] ONE_Q24         = 25'h100_0000;
    localparam logic [15:0] REFL_MAX        = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_ETA_OUTSIDE = 2'd0,
        REG_ETA_INSIDE  = 2'd1
    } t_reg_idx;

    // per-item context that rides along with the valid bits
    typedef struct packed {
        logic        tir;
        logic        z_par;
        logic        z_perp;
        logic [16:0] m;
        logic [15:0] ei;
        logic [15:0] et;
    } t_ctx;

    typedef struct packed {
        logic [31:0] rem;
        logic [15:0] root;
    } t_sq;

    typedef struct packed {
        logic [31:0] rem;
        logic        qbit;
    } t_dv;

    // one bit of a remainder-form integer square root, bit position k
    function automatic t_sq sq_step(input t_sq cur, input int unsigned k);
        logic [31:0] trial;
        t_sq         res;
        trial = ({16'd0, cur.root} << (k + 1)) | (32'd1 << (2 * k));
        res   = cur;
        if (cur.rem >= trial) begin
            res.rem  = cur.rem - trial;
            res.root = cur.root | (16'd1 << k);
        end
        return res;
    endfunction

    // one restoring division step, remainder stays below the divisor
    function automatic t_dv dv_step(input logic [31:0] rem, input logic [31:0] dvs,
                                    input logic in_bit);
        logic [32:0] t;
        t_dv         res;
        t = {rem, in_bit};
        if (t >= {1'b0, dvs}) begin
            res.rem  = 32'(t - {1'b0, dvs});
            res.qbit = 1'b1;
        end else begin
            res.rem  = t[31:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

### hdl/fresnel_dielectric_reflectance.sv
// Top level: fully pipelined unpolarized Fresnel reflectance of a dielectric interface.
`timescale 1ns / 1ps
//
// Usage:
//   s_axis_*  : one word per ray hit, tdata = cos_incident (signed Q1.15).
//   m_axis_*  : one word per input word, tdata = reflectance (Q0.16, saturated),
//               tuser = total_internal.
//   cfg       : i_cfg_index selects eta_outside (0) or eta_inside (1), Q4.12;
//               other indexes are dropped. o_cfg_ready is always high. Write only
//               while the pipe is empty.
// Timing:
//   Throughput is one word per cycle while m_axis_tready does not stall the
//   pipe. Depth is set by the two 16-step square roots, the 31-step cosine
//   division and the 25-step ratio dividers, one bit per stage.
// Reset (synchronous, active low) clears all valid bits and loads the indices
//   with 1.0 and 1.5.
// Stall: when m_axis_tready is low while a result is held, the whole pipe
//   freezes and s_axis_tready drops; nothing is lost or repeated.
//
module fresnel_dielectric_reflectance
    import fdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] cos_incident
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] reflectance
    output logic        m_axis_tuser,   // [0] total_internal
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // stage map
    localparam int unsigned S_MM   = 1;
    localparam int unsigned S_SQ1  = 2;
    localparam int unsigned S_TIR  = S_SQ1 + SQ_STEPS;
    localparam int unsigned S_P2   = S_TIR + 1;
    localparam int unsigned S_NUM  = S_P2 + 1;
    localparam int unsigned S_DIV  = S_NUM + 1;
    localparam int unsigned S_SQ2  = S_DIV + DIV_STEPS;
    localparam int unsigned S_PRD  = S_SQ2 + SQ_STEPS;
    localparam int unsigned S_DN   = S_PRD + 1;
    localparam int unsigned S_RAT  = S_DN + 1;
    localparam int unsigned S_SQR  = S_RAT + RAT_STEPS;
    localparam int unsigned LAST   = S_SQR + 1;

    logic        ce;
    logic [15:0] r_eta_out, r_eta_in;
    logic [LAST:0] r_vld;
    t_ctx        r_ctx [0:LAST];

    logic [30:0] r_mm;
    t_sq         r_sq1 [0:SQ_STEPS-1];
    logic [31:0] r_p, r_et2, r_et2b, r_et2c;
    logic [63:0] r_p2;
    logic [61:0] r_num;
    t_sq         r_sq2 [0:SQ_STEPS-1];
    logic [31:0] r_dv_rem [0:DIV_STEPS-1];
    logic [30:0] r_dv_q   [0:DIV_STEPS-1];
    logic [29:0] r_dv_lo  [0:DIV_STEPS-1];
    logic [31:0] r_dv_d   [0:DIV_STEPS-1];
    logic [31:0] r_x1, r_y1, r_x2, r_y2;
    logic [31:0] r_d1, r_n1, r_d2, r_n2;
    logic [31:0] r_ra_rem [0:RAT_STEPS-1];
    logic [24:0] r_ra_q   [0:RAT_STEPS-1];
    logic [31:0] r_ra_n   [0:RAT_STEPS-1];
    logic        r_ra_lsb [0:RAT_STEPS-1];
    logic [31:0] r_rb_rem [0:RAT_STEPS-1];
    logic [24:0] r_rb_q   [0:RAT_STEPS-1];
    logic [31:0] r_rb_n   [0:RAT_STEPS-1];
    logic        r_rb_lsb [0:RAT_STEPS-1];
    logic [48:0] r_sp, r_sq;
    logic [15:0] r_refl;

    // input side: leaving rays (negative or zero cosine) swap the indices
    logic        neg, leave;
    logic [16:0] m_in;
    t_ctx        ctx_in;

    always_comb begin
        neg    = s_axis_tdata[15];
        leave  = neg || (s_axis_tdata == 16'd0);
        m_in   = neg ? 17'(17'h10000 - {1'b0, s_axis_tdata}) : {1'b0, s_axis_tdata};
        ctx_in = '0;
        ctx_in.m  = m_in;
        ctx_in.ei = leave ? r_eta_in  : r_eta_out;
        ctx_in.et = leave ? r_eta_out : r_eta_in;
    end

    assign ce            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = ce;
    assign o_cfg_ready   = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta_out <= ETA_OUTSIDE_RST;
            r_eta_in  <= ETA_INSIDE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ETA_OUTSIDE: r_eta_out <= i_cfg_data;
                REG_ETA_INSIDE:  r_eta_in  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[LAST-1:0], s_axis_tvalid};
        end
    end

    // stage-local combinational pieces
    logic [31:0] p_tir;
    logic [31:0] x_span;
    logic [24:0] rp_fin, rs_fin;
    logic [49:0] sum_fin;
    logic [16:0] refl_wide;

    always_comb begin
        p_tir     = 32'(r_ctx[S_TIR-1].ei * r_sq1[SQ_STEPS-1].root);
        x_span    = {1'b0, r_ctx[S_TIR-1].et, 15'd0};
        rp_fin    = r_ctx[S_SQR-1].z_par  ? ONE_Q24 : r_ra_q[RAT_STEPS-1];
        rs_fin    = r_ctx[S_SQR-1].z_perp ? ONE_Q24 : r_rb_q[RAT_STEPS-1];
        sum_fin   = {1'b0, r_sp} + {1'b0, r_sq};
        refl_wide = sum_fin[49:33];
    end

    // next context per stage, flags filled in where they are found
    t_ctx ctx_nx [1:LAST];

    always_comb begin
        for (int i = 1; i <= LAST; i++) begin
            ctx_nx[i] = r_ctx[i-1];
        end
        ctx_nx[S_TIR].tir   = (p_tir >= x_span);
        ctx_nx[S_DN].z_par  = (32'(r_x1 + r_y1) == 32'd0);
        ctx_nx[S_DN].z_perp = (32'(r_x2 + r_y2) == 32'd0);
    end

    // divider steps of the cosine division and both ratio dividers
    t_dv dv_nx [0:DIV_STEPS-1];
    t_dv ra_nx [0:RAT_STEPS-1];
    t_dv rb_nx [0:RAT_STEPS-1];

    always_comb begin
        dv_nx[0] = dv_step({1'b0, r_num[61:31]}, r_et2c, r_num[30]);
        for (int j = 1; j < DIV_STEPS; j++) begin
            dv_nx[j] = dv_step(r_dv_rem[j-1], r_dv_d[j-1], r_dv_lo[j-1][29]);
        end
        ra_nx[0] = dv_step({1'b0, r_d1[31:1]}, r_n1, r_d1[0]);
        rb_nx[0] = dv_step({1'b0, r_d2[31:1]}, r_n2, r_d2[0]);
        for (int j = 1; j < RAT_STEPS; j++) begin
            ra_nx[j] = dv_step(r_ra_rem[j-1], r_ra_n[j-1], r_ra_lsb[j-1]);
            rb_nx[j] = dv_step(r_rb_rem[j-1], r_rb_n[j-1], r_rb_lsb[j-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            // context line
            r_ctx[0] <= ctx_in;
            for (int i = 1; i <= LAST; i++) begin
                r_ctx[i] <= ctx_nx[i];
            end

            // sine of incidence: floor(sqrt(2^30 - m^2))
            r_mm <= 31'(r_ctx[S_MM-1].m * r_ctx[S_MM-1].m);
            for (int j = 0; j < SQ_STEPS; j++) begin
                if (j == 0) begin
                    r_sq1[j] <= sq_step('{rem: {1'b0, 31'(ONE_Q30 - r_mm)}, root: 16'd0},
                                        SQ_STEPS - 1);
                end else begin
                    r_sq1[j] <= sq_step(r_sq1[j-1], SQ_STEPS - 1 - j);
                end
            end

            // TIR test, then numerator et^2*2^30 - (ei*s)^2
            r_p    <= p_tir;
            r_et2  <= 32'(r_ctx[S_TIR-1].et * r_ctx[S_TIR-1].et);
            r_p2   <= r_p * r_p;
            r_et2b <= r_et2;
            r_num  <= 62'({r_et2b, 30'd0} - r_p2[61:0]);
            r_et2c <= r_et2b;

            // num / et^2, one quotient bit per stage
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (j == 0) begin
                    r_dv_rem[j] <= dv_nx[j].rem;
                    r_dv_q[j]   <= {30'd0, dv_nx[j].qbit};
                    r_dv_lo[j]  <= r_num[29:0];
                    r_dv_d[j]   <= r_et2c;
                end else begin
                    r_dv_rem[j] <= dv_nx[j].rem;
                    r_dv_q[j]   <= {r_dv_q[j-1][29:0], dv_nx[j].qbit};
                    r_dv_lo[j]  <= {r_dv_lo[j-1][28:0], 1'b0};
                    r_dv_d[j]   <= r_dv_d[j-1];
                end
            end

            // refracted cosine
            for (int j = 0; j < SQ_STEPS; j++) begin
                if (j == 0) begin
                    r_sq2[j] <= sq_step('{rem: {1'b0, r_dv_q[DIV_STEPS-1]}, root: 16'd0},
                                        SQ_STEPS - 1);
                end else begin
                    r_sq2[j] <= sq_step(r_sq2[j-1], SQ_STEPS - 1 - j);
                end
            end

            // index-times-cosine products, all below 2^31
            r_x1 <= 32'(r_ctx[S_PRD-1].et * r_ctx[S_PRD-1].m);
            r_y1 <= 32'(r_ctx[S_PRD-1].ei * r_sq2[SQ_STEPS-1].root);
            r_x2 <= 32'(r_ctx[S_PRD-1].ei * r_ctx[S_PRD-1].m);
            r_y2 <= 32'(r_ctx[S_PRD-1].et * r_sq2[SQ_STEPS-1].root);

            r_d1 <= (r_x1 > r_y1) ? (r_x1 - r_y1) : (r_y1 - r_x1);
            r_n1 <= 32'(r_x1 + r_y1);
            r_d2 <= (r_x2 > r_y2) ? (r_x2 - r_y2) : (r_y2 - r_x2);
            r_n2 <= 32'(r_x2 + r_y2);

            // (d << 24) / n for both polarizations
            for (int j = 0; j < RAT_STEPS; j++) begin
                if (j == 0) begin
                    r_ra_rem[j] <= ra_nx[j].rem;
                    r_ra_q[j]   <= {24'd0, ra_nx[j].qbit};
                    r_ra_n[j]   <= r_n1;
                    r_ra_lsb[j] <= 1'b0;
                    r_rb_rem[j] <= rb_nx[j].rem;
                    r_rb_q[j]   <= {24'd0, rb_nx[j].qbit};
                    r_rb_n[j]   <= r_n2;
                    r_rb_lsb[j] <= 1'b0;
                end else begin
                    r_ra_rem[j] <= ra_nx[j].rem;
                    r_ra_q[j]   <= {r_ra_q[j-1][23:0], ra_nx[j].qbit};
                    r_ra_n[j]   <= r_ra_n[j-1];
                    r_ra_lsb[j] <= r_ra_lsb[j-1];
                    r_rb_rem[j] <= rb_nx[j].rem;
                    r_rb_q[j]   <= {r_rb_q[j-1][23:0], rb_nx[j].qbit};
                    r_rb_n[j]   <= r_rb_n[j-1];
                    r_rb_lsb[j] <= r_rb_lsb[j-1];
                end
            end

            // squares, sum, saturate
            r_sp <= 49'(rp_fin * rp_fin);
            r_sq <= 49'(rs_fin * rs_fin);
            if (r_ctx[LAST-1].tir || refl_wide[16]) begin
                r_refl <= REFL_MAX;
            end else begin
                r_refl <= refl_wide[15:0];
            end
        end
    end

    assign m_axis_tvalid = r_vld[LAST];
    assign m_axis_tdata  = r_refl;
    assign m_axis_tuser  = r_ctx[LAST].tir;

endmodule

### hdl/fdr_checker.sv
// Port-level checker for the Fresnel reflectance block, bound to the top level.
`timescale 1ns / 1ps

module fdr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // held result word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result word changed under stall");

    // total internal reflection always reports full reflectance
    a_tir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'hFFFF)
        else $error("TIR word without full reflectance");

    // output empty right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("valid output after reset");

    // an empty output slot never blocks the input
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output free");

endmodule

bind fresnel_dielectric_reflectance fdr_checker u_fdr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
